### hdl/lida_pkg.sv
// ----------------------------------------------------------------------------
// lida_pkg
// Shared types and constants of the LIFO ID allocator: field widths, command
// and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package lida_pkg;

	localparam int CMD_W     = 2;
	localparam int DEV_W     = 2;
	localparam int MID_W     = 9;
	localparam int STS_W     = 2;
	localparam int GID_W     = 8;
	localparam int LEFT_W    = 9;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT    = 2'd0,
		CMD_ALLOC   = 2'd1,
		CMD_FREE    = 2'd2,
		CMD_DESTROY = 2'd3
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK        = 2'd0,
		STS_INVALID   = 2'd1,
		STS_NODATA    = 2'd2,
		STS_EXHAUSTED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ALLOC,
		ST_FREE,
		ST_SWEEP,
		ST_RESP
	} state_t;

endpackage

### hdl/lifo_id_allocator.sv
// ----------------------------------------------------------------------------
// lifo_id_allocator
// Per-device pools of numeric IDs kept as a LIFO free list in a stack memory,
// with an allocation bit memory that rejects frees of IDs not handed out.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (lowest bit first)
//  s_axis    in         command[1:0], device_id[3:2], release_id[12:4], zero pad
//  m_axis    out        status[1:0], granted_id[9:2], free_left[18:10], zero pad
//
//  Allocate and free go from request to result in these steps: decode and
//  read the stack or allocation memory, modify and write back, load output.
//  Init and destroy sweep all MAX_IDS entries of the pool.
//  Invalid requests and empty-pool errors answer straight from decode.
//  After reset the whole allocation memory is cleared,
//  with s_axis_tready low. A new request is taken while a result waits.
//
module lifo_id_allocator #(
	parameter int MAX_IDS = 64,
	parameter int DEVICES = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// command[1:0], device_id[3:2], release_id[12:4]
	input  logic [lida_pkg::S_TDATA_W-1:0] s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status[1:0], granted_id[9:2], free_left[18:10]
	output logic [lida_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	localparam int DEPTH = DEVICES * MAX_IDS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int DW    = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam int CW    = $clog2(MAX_IDS + 1);

	function automatic logic [AW-1:0] pool_addr(input logic [DW-1:0] d,
	                                            input logic [IW-1:0] i);
		return AW'(d) * AW'(MAX_IDS) + AW'(i);
	endfunction

	// memories
	logic [7:0] stack_mem [DEPTH];
	logic       map_mem   [DEPTH];

	logic            stack_we;
	logic [AW-1:0]   stack_waddr;
	logic [7:0]      stack_wdata;
	logic [AW-1:0]   stack_raddr;
	logic [7:0]      stack_rd_q;
	logic            map_we;
	logic [AW-1:0]   map_waddr;
	logic            map_wdata;
	logic [AW-1:0]   map_raddr;
	logic            map_rd_q;

	// control and request registers
	lida_pkg::state_t state_q, state_d;
	lida_pkg::cmd_t   cmd_q;
	logic [DW-1:0]    dev_q;
	logic [IW-1:0]    id_q;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    sweep_q, sweep_d;
	logic [CW-1:0]    count_q [DEVICES];
	logic             count_we;
	logic [CW-1:0]    count_wdata;

	lida_pkg::status_t          resp_status_q, resp_status_d;
	logic [lida_pkg::GID_W-1:0]  resp_granted_q, resp_granted_d;
	logic [lida_pkg::LEFT_W-1:0] resp_left_q, resp_left_d;
	logic                        resp_we;

	logic                        out_valid_q;
	logic                        out_load;
	lida_pkg::status_t           out_status_q;
	logic [lida_pkg::GID_W-1:0]  out_granted_q;
	logic [lida_pkg::LEFT_W-1:0] out_left_q;

	// request decode
	lida_pkg::cmd_t              in_cmd;
	logic [lida_pkg::DEV_W-1:0]  in_dev;
	logic [lida_pkg::MID_W-1:0]  in_id;
	logic                        in_accept;
	logic                        dev_ok;
	logic                        id_ok;
	logic [DW-1:0]               in_dev_ix;
	logic [CW-1:0]               in_cnt;

	assign in_cmd    = lida_pkg::cmd_t'(s_axis_tdata[1:0]);
	assign in_dev    = s_axis_tdata[3:2];
	assign in_id     = s_axis_tdata[12:4];
	assign in_dev_ix = in_dev[DW-1:0];
	assign dev_ok    = (3'(in_dev) < 3'(DEVICES));
	assign id_ok     = (in_id < lida_pkg::MID_W'(MAX_IDS));
	assign in_cnt    = dev_ok ? count_q[in_dev_ix] : '0;

	assign s_axis_tready = (state_q == lida_pkg::ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d        = state_q;
		sweep_d        = sweep_q;
		stack_we       = 1'b0;
		stack_waddr    = '0;
		stack_wdata    = '0;
		stack_raddr    = '0;
		map_we         = 1'b0;
		map_waddr      = '0;
		map_wdata      = 1'b0;
		map_raddr      = '0;
		count_we       = 1'b0;
		count_wdata    = '0;
		resp_we        = 1'b0;
		resp_status_d  = lida_pkg::STS_OK;
		resp_granted_d = '0;
		resp_left_d    = '0;
		out_load       = 1'b0;

		unique case (state_q)
			lida_pkg::ST_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = sweep_q;
				if (sweep_q == AW'(DEPTH - 1)) begin
					sweep_d = '0;
					state_d = lida_pkg::ST_IDLE;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end

			lida_pkg::ST_IDLE: begin
				if (in_accept) begin
					resp_left_d = lida_pkg::LEFT_W'(in_cnt);
					if (!dev_ok) begin
						resp_we       = 1'b1;
						resp_status_d = lida_pkg::STS_INVALID;
						resp_left_d   = '0;
						state_d       = lida_pkg::ST_RESP;
					end else begin
						unique case (in_cmd)
							lida_pkg::CMD_INIT: begin
								sweep_d = '0;
								state_d = lida_pkg::ST_SWEEP;
							end
							lida_pkg::CMD_ALLOC: begin
								if (in_cnt == '0 || in_cnt > CW'(MAX_IDS)) begin
									resp_we       = 1'b1;
									resp_status_d = lida_pkg::STS_EXHAUSTED;
									state_d       = lida_pkg::ST_RESP;
								end else begin
									stack_raddr = pool_addr(in_dev_ix, IW'(in_cnt - 1'b1));
									state_d     = lida_pkg::ST_ALLOC;
								end
							end
							lida_pkg::CMD_FREE: begin
								if (!id_ok) begin
									resp_we       = 1'b1;
									resp_status_d = lida_pkg::STS_INVALID;
									state_d       = lida_pkg::ST_RESP;
								end else begin
									map_raddr = pool_addr(in_dev_ix, in_id[IW-1:0]);
									state_d   = lida_pkg::ST_FREE;
								end
							end
							default: begin
								if (in_cnt == '0) begin
									resp_we       = 1'b1;
									resp_status_d = lida_pkg::STS_NODATA;
									state_d       = lida_pkg::ST_RESP;
								end else begin
									sweep_d = '0;
									state_d = lida_pkg::ST_SWEEP;
								end
							end
						endcase
					end
				end
			end

			lida_pkg::ST_ALLOC: begin
				// mark the popped ID as handed out
				if (9'(stack_rd_q) < 9'(MAX_IDS)) begin
					map_we    = 1'b1;
					map_waddr = pool_addr(dev_q, stack_rd_q[IW-1:0]);
					map_wdata = 1'b1;
				end
				count_we       = 1'b1;
				count_wdata    = cnt_q - 1'b1;
				resp_we        = 1'b1;
				resp_status_d  = lida_pkg::STS_OK;
				resp_granted_d = stack_rd_q;
				resp_left_d    = lida_pkg::LEFT_W'(cnt_q - 1'b1);
				state_d        = lida_pkg::ST_RESP;
			end

			lida_pkg::ST_FREE: begin
				resp_we = 1'b1;
				if (!map_rd_q || cnt_q >= CW'(MAX_IDS)) begin
					resp_status_d = lida_pkg::STS_NODATA;
					resp_left_d   = lida_pkg::LEFT_W'(cnt_q);
				end else begin
					map_we        = 1'b1;
					map_waddr     = pool_addr(dev_q, id_q);
					map_wdata     = 1'b0;
					stack_we      = 1'b1;
					stack_waddr   = pool_addr(dev_q, cnt_q[IW-1:0]);
					stack_wdata   = 8'(id_q);
					count_we      = 1'b1;
					count_wdata   = cnt_q + 1'b1;
					resp_status_d = lida_pkg::STS_OK;
					resp_left_d   = lida_pkg::LEFT_W'(cnt_q + 1'b1);
				end
				state_d = lida_pkg::ST_RESP;
			end

			lida_pkg::ST_SWEEP: begin
				map_we    = 1'b1;
				map_waddr = pool_addr(dev_q, sweep_q[IW-1:0]);
				// init refills the stack top-down so that ID 0 leaves first
				if (cmd_q == lida_pkg::CMD_INIT) begin
					stack_we    = 1'b1;
					stack_waddr = pool_addr(dev_q, sweep_q[IW-1:0]);
					stack_wdata = 8'(MAX_IDS - 1) - 8'(sweep_q[IW-1:0]);
				end
				if (sweep_q == AW'(MAX_IDS - 1)) begin
					count_we      = 1'b1;
					count_wdata   = (cmd_q == lida_pkg::CMD_INIT) ? CW'(MAX_IDS) : '0;
					resp_we       = 1'b1;
					resp_status_d = lida_pkg::STS_OK;
					resp_left_d   = (cmd_q == lida_pkg::CMD_INIT) ?
					                lida_pkg::LEFT_W'(MAX_IDS) : '0;
					sweep_d       = '0;
					state_d       = lida_pkg::ST_RESP;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end

			lida_pkg::ST_RESP: begin
				// hold until the output register is free
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = lida_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = lida_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lida_pkg::ST_CLEAR;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DEVICES; d++) begin
				count_q[d] <= '0;
			end
		end else if (count_we) begin
			count_q[dev_q] <= count_wdata;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q <= in_cmd;
			dev_q <= in_dev_ix;
			id_q  <= in_id[IW-1:0];
			cnt_q <= in_cnt;
		end
		if (resp_we) begin
			resp_status_q  <= resp_status_d;
			resp_granted_q <= resp_granted_d;
			resp_left_q    <= resp_left_d;
		end
		if (out_load) begin
			out_status_q  <= resp_status_q;
			out_granted_q <= resp_granted_q;
			out_left_q    <= resp_left_q;
		end
	end

	always_ff @(posedge clk) begin
		stack_rd_q <= stack_mem[stack_raddr];
		if (stack_we) begin
			stack_mem[stack_waddr] <= stack_wdata;
		end
	end

	always_ff @(posedge clk) begin
		map_rd_q <= map_mem[map_raddr];
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_left_q, out_granted_q, out_status_q};

endmodule
